@@ sv/ccls_pkg.sv @@
// Shared types, constants and register defaults for the charge/comm line sequencer.
package ccls_pkg;

    localparam int TX_DEPTH_DEF = 64;
    localparam int NUM_REGS     = 8;
    localparam int REG_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 8;

    localparam logic [REG_W-1:0] GUARD_TICKS = 16'd30;
    localparam logic [REG_W-1:0] ELAPSED_MAX = 16'hFFFF;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        16'd300, 16'd250, 16'd290, 16'd1, 16'd100, 16'd10, 16'd341, 16'd40
    };

    typedef enum logic [2:0] {
        REG_CHARGE      = 3'd0,
        REG_WAIT_LOW    = 3'd1,
        REG_RECEIVE     = 3'd2,
        REG_RX_TO_TX    = 3'd3,
        REG_TRANSMIT    = 3'd4,
        REG_TX_TO_CHG   = 3'd5,
        REG_RECOVER     = 3'd6,
        REG_DISCHARGE   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_HOST   = 2'd1,
        ACT_DEVICE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        M_CHG        = 3'd0,
        M_CHG_TO_RX  = 3'd1,
        M_RX         = 3'd2,
        M_RX_TO_TX   = 3'd3,
        M_TX         = 3'd4,
        M_TX_TO_CHG  = 3'd5,
        M_RST_TO_CHG = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMP,
        ST_GUARD,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_EMIT
    } t_state;

    // Request into the shared add/compare unit: (x + y) > b, or >= b when ge.
    typedef struct packed {
        logic [REG_W-1:0] x;
        logic [REG_W-1:0] y;
        logic [REG_W-1:0] b;
        logic             ge;
    } t_cmp_req;

    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
    } t_fifo_stat;

endpackage

@@ sv/ccls_cmp_unit.sv @@
// Shared add/compare unit: every timeout, guard and discharge test goes through it.
module ccls_cmp_unit (
    input  ccls_pkg::t_cmp_req i_req,
    output logic               o_hit
);

    logic [ccls_pkg::REG_W:0] sum;
    logic [ccls_pkg::REG_W:0] bound;

    // Sum is one bit wider, so elapsed plus wait time never wraps.
    assign sum   = {1'b0, i_req.x} + {1'b0, i_req.y};
    assign bound = {1'b0, i_req.b};
    assign o_hit = i_req.ge ? (sum >= bound) : (sum > bound);

endmodule

@@ sv/ccls_tx_fifo.sv @@
// Transmit byte FIFO: circular store with head pointer, fill count and registered read.
module ccls_tx_fifo #(
    parameter int DEPTH = ccls_pkg::TX_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [ccls_pkg::BYTE_W-1:0] i_push_data,
    input  logic                        i_pop,
    output logic [ccls_pkg::BYTE_W-1:0] o_rd_data,
    output ccls_pkg::t_fifo_stat        o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [ccls_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [ccls_pkg::BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_count;
    logic [AW-1:0]               n_head;
    logic [CW-1:0]               n_count;
    logic [SW-1:0]               wr_sum;
    logic [SW-1:0]               wr_fold;

    // head + count stays below twice the depth: one compare and subtract wraps it
    assign wr_sum  = SW'(r_head) + SW'(r_count);
    assign wr_fold = (wr_sum >= SW'(DEPTH)) ? (wr_sum - SW'(DEPTH)) : wr_sum;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[wr_fold[AW-1:0]] <= i_push_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    assign o_rd_data       = r_rd_data;
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.one_left = (r_count == CW'(1));

endmodule

@@ sv/charge_comm_line_sequencer_core.sv @@
// Top level of the charge/comm line sequencer: registers, sequencer and output stage.
//
//  channel  | signals                                   | payload
//  ---------+-------------------------------------------+---------------------------------
//  in       | s_axis_tvalid/tready/tdata/tuser          | tuser action, tdata byte+line_low
//  out      | m_axis_tvalid/tready/tdata/tuser/tlast    | status / forwarded byte per item
//  config   | i_cfg_valid/o_cfg_ready/i_cfg_index/data  | timeout register write
//
// Steps after an accept (input not ready): host byte or unused action decode, emit;
// device byte or tick decode, compare, emit; tick in transmit with a send pending adds
// guard, then emit or, draining a non-empty FIFO, a read and a place step per byte.
// All tests use the single add/compare unit; the FIFO's registered read port sets the drain pace.
// Reset (sync, active low) puts the block in charge mode with an empty FIFO and
// register defaults; no clearing pass. A stalled output holds the sequencer only
// when it has a new item result to place; the input is taken while the last
// result of the previous item still waits.
module charge_comm_line_sequencer_core #(
    parameter int TX_DEPTH = ccls_pkg::TX_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [7:0] data_byte, [8] line_low
    input  logic [1:0]                     s_axis_tuser,   // [1:0] action
    // result item
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] mode, [3] charge_relay, [4] receive_relay, [5] transmit_relay,
    // [6] charge_led, [14:7] out_byte, [15] fifo_overflow
    output logic [15:0]                    m_axis_tdata,
    output logic [1:0]                     m_axis_tuser,   // [0] to_host_valid, [1] to_device_valid
    output logic                           m_axis_tlast,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ccls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccls_pkg::REG_W-1:0]     i_cfg_data
);

    localparam int RW = ccls_pkg::REG_W;
    localparam int BW = ccls_pkg::BYTE_W;

    // timeout registers
    logic [RW-1:0] r_regs [ccls_pkg::NUM_REGS];

    // sequencer and line state
    ccls_pkg::t_state  r_state, n_state;
    ccls_pkg::t_mode   r_mode, n_mode;
    logic [RW-1:0]     r_elapsed, n_elapsed;
    logic [RW-1:0]     r_wait, n_wait;
    logic              r_send, n_send;

    // captured input item
    ccls_pkg::t_action r_act;
    logic [BW-1:0]     r_byte;
    logic              r_line_low;

    // result flags of the current item
    logic              r_host, n_host;
    logic              r_ovf, n_ovf;

    // output stage
    logic              r_out_valid;
    logic [15:0]       r_out_data;
    logic [1:0]        r_out_user;
    logic              r_out_last;

    logic              in_accept;
    logic              slot_free;
    logic              out_load;
    logic              out_to_host;
    logic              out_to_dev;
    logic [BW-1:0]     out_byte;
    logic              out_last;
    logic              out_ovf;

    ccls_pkg::t_cmp_req   cmp_req;
    logic                 cmp_hit;
    ccls_pkg::t_fifo_stat fifo_stat;
    logic [BW-1:0]        fifo_rd_data;
    logic                 fifo_push;
    logic                 fifo_pop;

    assign s_axis_tready = (r_state == ccls_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    ccls_cmp_unit u_cmp (
        .i_req (cmp_req),
        .o_hit (cmp_hit)
    );

    ccls_tx_fifo #(
        .DEPTH (TX_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fifo_push),
        .i_push_data (r_byte),
        .i_pop       (fifo_pop),
        .o_rd_data   (fifo_rd_data),
        .o_stat      (fifo_stat)
    );

    // Configuration writes; indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= ccls_pkg::REG_RESET;
        end else if (i_cfg_valid && (i_cfg_index < ccls_pkg::CFG_IDX_W'(ccls_pkg::NUM_REGS))) begin
            r_regs[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_act      <= ccls_pkg::t_action'(s_axis_tuser);
            r_byte     <= s_axis_tdata[7:0];
            r_line_low <= s_axis_tdata[8];
        end
    end

    // Sequencer: one test on the shared unit per step.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_wait      = r_wait;
        n_send      = r_send;
        n_host      = r_host;
        n_ovf       = r_ovf;
        fifo_push   = 1'b0;
        fifo_pop    = 1'b0;
        out_load    = 1'b0;
        out_to_host = 1'b0;
        out_to_dev  = 1'b0;
        out_byte    = '0;
        out_last    = 1'b1;
        out_ovf     = 1'b0;

        cmp_req.x  = r_elapsed;
        cmp_req.y  = '0;
        cmp_req.ge = 1'b0;
        case (r_mode)
            ccls_pkg::M_CHG:        cmp_req.b = r_regs[ccls_pkg::REG_CHARGE];
            ccls_pkg::M_CHG_TO_RX:  cmp_req.b = r_regs[ccls_pkg::REG_WAIT_LOW];
            ccls_pkg::M_RX:         cmp_req.b = r_regs[ccls_pkg::REG_RECEIVE];
            ccls_pkg::M_RX_TO_TX:   cmp_req.b = r_regs[ccls_pkg::REG_RX_TO_TX];
            ccls_pkg::M_TX:         cmp_req.b = r_regs[ccls_pkg::REG_TRANSMIT];
            ccls_pkg::M_TX_TO_CHG:  cmp_req.b = r_regs[ccls_pkg::REG_TX_TO_CHG];
            ccls_pkg::M_RST_TO_CHG: cmp_req.b = r_regs[ccls_pkg::REG_RECOVER];
            default:                cmp_req.b = r_regs[ccls_pkg::REG_CHARGE];
        endcase

        case (r_state)
            ccls_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = ccls_pkg::ST_DECODE;
                end
            end

            ccls_pkg::ST_DECODE: begin
                n_host = 1'b0;
                n_ovf  = 1'b0;
                case (r_act)
                    ccls_pkg::ACT_TICK: begin
                        if (r_elapsed != ccls_pkg::ELAPSED_MAX) begin
                            n_elapsed = r_elapsed + 1'b1;
                        end
                        n_state = ccls_pkg::ST_CMP;
                    end
                    ccls_pkg::ACT_HOST: begin
                        if (fifo_stat.full) begin
                            n_ovf = 1'b1;
                        end else begin
                            fifo_push = 1'b1;
                        end
                        n_state = ccls_pkg::ST_EMIT;
                    end
                    ccls_pkg::ACT_DEVICE: n_state = ccls_pkg::ST_CMP;
                    default:              n_state = ccls_pkg::ST_EMIT;
                endcase
            end

            ccls_pkg::ST_CMP: begin
                n_state = ccls_pkg::ST_EMIT;
                if (r_act == ccls_pkg::ACT_DEVICE) begin
                    // discharge window: nonzero bytes pass in receive mode once elapsed >= discharge_time
                    cmp_req.b  = r_regs[ccls_pkg::REG_DISCHARGE];
                    cmp_req.ge = 1'b1;
                    n_host = (r_mode == ccls_pkg::M_RX) && cmp_hit && (r_byte != '0);
                end else begin
                    case (r_mode)
                        ccls_pkg::M_CHG: begin
                            if (cmp_hit) begin
                                n_mode    = ccls_pkg::M_CHG_TO_RX;
                                n_elapsed = '0;
                            end
                        end
                        ccls_pkg::M_CHG_TO_RX: begin
                            n_wait = r_elapsed;
                            if (cmp_hit) begin
                                n_mode    = ccls_pkg::M_RST_TO_CHG;
                                n_elapsed = '0;
                            end else if (r_line_low) begin
                                n_mode    = ccls_pkg::M_RX;
                                n_elapsed = '0;
                            end
                        end
                        ccls_pkg::M_RX: begin
                            cmp_req.y = r_wait;
                            if (cmp_hit) begin
                                n_mode    = ccls_pkg::M_RX_TO_TX;
                                n_elapsed = '0;
                            end
                        end
                        ccls_pkg::M_RX_TO_TX: begin
                            if (cmp_hit) begin
                                n_mode    = ccls_pkg::M_TX;
                                n_elapsed = '0;
                                n_send    = 1'b1;
                            end
                        end
                        ccls_pkg::M_TX: begin
                            if (cmp_hit) begin
                                n_mode    = ccls_pkg::M_TX_TO_CHG;
                                n_elapsed = '0;
                            end else if (r_send) begin
                                n_state = ccls_pkg::ST_GUARD;
                            end
                        end
                        ccls_pkg::M_TX_TO_CHG,
                        ccls_pkg::M_RST_TO_CHG: begin
                            if (cmp_hit) begin
                                n_mode    = ccls_pkg::M_CHG;
                                n_elapsed = '0;
                            end
                        end
                        default: begin
                            n_mode    = ccls_pkg::M_CHG;
                            n_elapsed = '0;
                        end
                    endcase
                end
            end

            ccls_pkg::ST_GUARD: begin
                cmp_req.b  = ccls_pkg::GUARD_TICKS;
                cmp_req.ge = 1'b1;
                n_state    = ccls_pkg::ST_EMIT;
                if (cmp_hit) begin
                    n_send = 1'b0;
                    if (!fifo_stat.empty) begin
                        n_state = ccls_pkg::ST_DRAIN_RD;
                    end
                end
            end

            // head entry lands in the FIFO's read register
            ccls_pkg::ST_DRAIN_RD: n_state = ccls_pkg::ST_DRAIN_OUT;

            ccls_pkg::ST_DRAIN_OUT: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_to_dev = 1'b1;
                    out_byte   = fifo_rd_data;
                    out_last   = fifo_stat.one_left;
                    fifo_pop   = 1'b1;
                    n_state    = fifo_stat.one_left ? ccls_pkg::ST_IDLE
                                                    : ccls_pkg::ST_DRAIN_RD;
                end
            end

            ccls_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_load    = 1'b1;
                    out_to_host = r_host;
                    out_byte    = r_host ? r_byte : '0;
                    out_ovf     = r_ovf;
                    n_state     = ccls_pkg::ST_IDLE;
                end
            end

            default: n_state = ccls_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ccls_pkg::ST_IDLE;
            r_mode    <= ccls_pkg::M_CHG;
            r_elapsed <= '0;
            r_wait    <= '0;
            r_send    <= 1'b0;
            r_host    <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
            r_wait    <= n_wait;
            r_send    <= n_send;
            r_host    <= n_host;
            r_ovf     <= n_ovf;
        end
    end

    // Output register; relay drives follow the mode after the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data[2:0]  <= r_mode;
            r_out_data[3]    <= (r_mode == ccls_pkg::M_CHG);
            r_out_data[4]    <= (r_mode == ccls_pkg::M_CHG_TO_RX) || (r_mode == ccls_pkg::M_RX);
            r_out_data[5]    <= (r_mode == ccls_pkg::M_RX_TO_TX) || (r_mode == ccls_pkg::M_TX)
                                || (r_mode == ccls_pkg::M_TX_TO_CHG);
            r_out_data[6]    <= (r_mode == ccls_pkg::M_CHG);
            r_out_data[14:7] <= out_byte;
            r_out_data[15]   <= out_ovf;
            r_out_user       <= {out_to_dev, out_to_host};
            r_out_last       <= out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule
